@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file nfalm_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define ASSERT_CLKD(label, clk_sig, rst_n_sig, prop) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error("assertion failed");

// clocked assertion on the default clk and arst_n
`define ASSERT_DFLT(label, prop) \
	`ASSERT_CLKD(label, clk, arst_n, prop)

`endif

@@ rtl/nfalm_pkg.sv @@
// constants, op codes and shared types of the nfa longest match engine
// no dependencies
package nfalm_pkg;

	localparam int NumEntries  = 32;
	localparam int IdxW        = $clog2(NumEntries);
	localparam int LengthBits  = 16;
	localparam int LenFieldW   = 16;
	localparam int OpW         = 2;
	localparam int ByteW       = 8;
	localparam int ApbDataW    = 32;
	localparam int ApbAddrW    = 3;

	localparam logic [OpW-1:0] OpLoad  = 2'd0;
	localparam logic [OpW-1:0] OpStart = 2'd1;
	localparam logic [OpW-1:0] OpByte  = 2'd2;
	localparam logic [OpW-1:0] OpEnd   = 2'd3;

	localparam logic RegStartMask    = 1'b0;
	localparam logic RegStartAccepts = 1'b1;

	typedef struct packed {
		logic start;
		logic step;
		logic clear;
	} cell_ctrl_t;

endpackage

@@ rtl/nfalm_if.sv @@
// valid/ready channels for input items and result items
// depends on nfalm_pkg
interface nfalm_in_if;
	logic                                valid;
	logic                                ready;
	logic [nfalm_pkg::OpW-1:0]           op;
	logic [4:0]                          entry_index;
	logic [nfalm_pkg::ByteW-1:0]         range_low;
	logic [nfalm_pkg::ByteW-1:0]         range_high;
	logic [nfalm_pkg::NumEntries-1:0]    successors;
	logic                                accept_after;
	logic [nfalm_pkg::ByteW-1:0]         text_byte;

	modport source (output valid, op, entry_index, range_low, range_high, successors,
		accept_after, text_byte, input ready);
	modport sink (input valid, op, entry_index, range_low, range_high, successors,
		accept_after, text_byte, output ready);
endinterface

interface nfalm_out_if;
	logic                                valid;
	logic                                ready;
	logic                                matched;
	logic [nfalm_pkg::LenFieldW-1:0]     length;

	modport source (output valid, matched, length, input ready);
	modport sink (input valid, matched, length, output ready);
endinterface

@@ rtl/nfalm_cell.sv @@
// one nfa entry: byte range, successor set, accept flag and active bit
// depends on nfalm_pkg
module nfalm_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic [nfalm_pkg::ByteW-1:0]       load_low,
	input  logic [nfalm_pkg::ByteW-1:0]       load_high,
	input  logic [nfalm_pkg::NumEntries-1:0]  load_succ,
	input  logic                              load_accept,
	input  nfalm_pkg::cell_ctrl_t             ctrl,
	input  logic                              start_bit,
	input  logic                              next_bit,
	input  logic [nfalm_pkg::ByteW-1:0]       text_byte,
	input  logic [nfalm_pkg::NumEntries-1:0]  succ_in,
	input  logic                              acc_in,
	output logic [nfalm_pkg::NumEntries-1:0]  succ_out,
	output logic                              acc_out
);

	logic [nfalm_pkg::ByteW-1:0]      low_q;
	logic [nfalm_pkg::ByteW-1:0]      high_q;
	logic [nfalm_pkg::NumEntries-1:0] succ_q;
	logic                             accept_q;
	logic                             active_q;
	logic                             hit;

	always_ff @(posedge clk) begin
		if (load) begin
			low_q    <= load_low;
			high_q   <= load_high;
			succ_q   <= load_succ;
			accept_q <= load_accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (ctrl.start) begin
			active_q <= start_bit;
		end else if (ctrl.step) begin
			active_q <= next_bit;
		end else if (ctrl.clear) begin
			active_q <= 1'b0;
		end
	end

	assign hit      = active_q && (text_byte >= low_q) && (text_byte <= high_q);
	assign succ_out = succ_in | (hit ? succ_q : '0);
	assign acc_out  = acc_in | (hit & accept_q);

endmodule

@@ rtl/nfalm_ctrl.sv @@
// match sequencer: byte count, best length, running flag and result register
// depends on nfalm_pkg
module nfalm_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              beat,
	input  logic [nfalm_pkg::OpW-1:0]         op,
	input  logic                              start_accepts,
	input  logic [nfalm_pkg::NumEntries-1:0]  next_set,
	input  logic                              acc_hit,
	input  logic                              out_ready,
	output nfalm_pkg::cell_ctrl_t             cell_ctrl,
	output logic                              in_ready,
	output logic                              out_valid,
	output logic                              out_matched,
	output logic [nfalm_pkg::LenFieldW-1:0]   out_length
);

	logic                             running_q;
	logic [nfalm_pkg::LengthBits-1:0] bytes_q;
	logic [nfalm_pkg::LengthBits-1:0] best_q;
	logic                             best_valid_q;
	logic                             out_valid_q;
	logic                             matched_q;
	logic [nfalm_pkg::LenFieldW-1:0]  length_q;
	logic [nfalm_pkg::LengthBits-1:0] bytes_inc;
	logic                             is_start;
	logic                             is_step;
	logic                             is_end;
	logic                             step_done;
	logic                             new_best_valid;
	logic [nfalm_pkg::LengthBits-1:0] new_best;
	logic                             emit;

	assign in_ready  = !out_valid_q || out_ready;
	assign is_start  = beat && (op == nfalm_pkg::OpStart);
	assign is_step   = beat && running_q && (op == nfalm_pkg::OpByte);
	assign is_end    = beat && running_q && (op == nfalm_pkg::OpEnd);
	assign bytes_inc = (bytes_q == '1) ? bytes_q : bytes_q + 1'b1;
	assign step_done = is_step && (next_set == '0);
	assign emit      = step_done || is_end;

	assign new_best_valid = (is_step && acc_hit) ? 1'b1 : best_valid_q;
	assign new_best       = (is_step && acc_hit) ? bytes_inc : best_q;

	assign cell_ctrl.start = is_start;
	assign cell_ctrl.step  = is_step;
	assign cell_ctrl.clear = is_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			bytes_q      <= '0;
			best_q       <= '0;
			best_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (is_start) begin
				running_q    <= 1'b1;
				bytes_q      <= '0;
				best_q       <= '0;
				best_valid_q <= start_accepts;
			end else if (is_step) begin
				bytes_q      <= bytes_inc;
				best_q       <= new_best;
				best_valid_q <= new_best_valid;
				if (step_done) begin
					running_q <= 1'b0;
				end
			end else if (is_end) begin
				running_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			matched_q <= new_best_valid;
			if (new_best_valid) begin
				length_q <= nfalm_pkg::LenFieldW'(new_best);
			end else begin
				length_q <= nfalm_pkg::LenFieldW'(is_step ? bytes_inc : bytes_q);
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_matched = matched_q;
	assign out_length  = length_q;

endmodule

@@ rtl/nfa_longest_match_engine.sv @@
// nfa longest match engine: the result shows in the cycle after the item's beat
// throughput one item per cycle while results are taken; set by the cell row, which
// merges all matching entries' successor sets in the same cycle the byte arrives
// async reset clears the active set, running flag, counters, output valid and registers
// table contents are not reset and read as undefined until loaded
module nfa_longest_match_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [nfalm_pkg::ApbAddrW-1:0]  paddr,
	input  logic [nfalm_pkg::ApbDataW-1:0]  pwdata,
	output logic [nfalm_pkg::ApbDataW-1:0]  prdata,
	output logic                            pready,
	nfalm_in_if.sink                        item_in,
	nfalm_out_if.source                     result_out
);

	logic [nfalm_pkg::NumEntries-1:0]                          start_mask_q;
	logic                                                      start_accepts_q;
	logic                                                      reg_sel;
	logic                                                      beat;
	logic                                                      load_beat;
	nfalm_pkg::cell_ctrl_t                                     cell_ctrl;
	logic [nfalm_pkg::NumEntries:0][nfalm_pkg::NumEntries-1:0] succ_chain;
	logic [nfalm_pkg::NumEntries:0]                            acc_chain;
	logic [nfalm_pkg::NumEntries-1:0]                          next_set;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_mask_q    <= '0;
			start_accepts_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				nfalm_pkg::RegStartMask:    start_mask_q <= pwdata[nfalm_pkg::NumEntries-1:0];
				nfalm_pkg::RegStartAccepts: start_accepts_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			nfalm_pkg::RegStartMask:    prdata = nfalm_pkg::ApbDataW'(start_mask_q);
			nfalm_pkg::RegStartAccepts: prdata = nfalm_pkg::ApbDataW'(start_accepts_q);
			default:                    prdata = '0;
		endcase
	end

	assign beat      = item_in.valid && item_in.ready;
	assign load_beat = beat && (item_in.op == nfalm_pkg::OpLoad);

	assign succ_chain[0] = '0;
	assign acc_chain[0]  = 1'b0;
	assign next_set      = succ_chain[nfalm_pkg::NumEntries];

	for (genvar i = 0; i < nfalm_pkg::NumEntries; i++) begin : g_cell
		nfalm_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.load        (load_beat && (item_in.entry_index == nfalm_pkg::IdxW'(i))),
			.load_low    (item_in.range_low),
			.load_high   (item_in.range_high),
			.load_succ   (item_in.successors),
			.load_accept (item_in.accept_after),
			.ctrl        (cell_ctrl),
			.start_bit   (start_mask_q[i]),
			.next_bit    (next_set[i]),
			.text_byte   (item_in.text_byte),
			.succ_in     (succ_chain[i]),
			.acc_in      (acc_chain[i]),
			.succ_out    (succ_chain[i+1]),
			.acc_out     (acc_chain[i+1])
		);
	end

	nfalm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.beat          (beat),
		.op            (item_in.op),
		.start_accepts (start_accepts_q),
		.next_set      (next_set),
		.acc_hit       (acc_chain[nfalm_pkg::NumEntries]),
		.out_ready     (result_out.ready),
		.cell_ctrl     (cell_ctrl),
		.in_ready      (item_in.ready),
		.out_valid     (result_out.valid),
		.out_matched   (result_out.matched),
		.out_length    (result_out.length)
	);

endmodule

@@ rtl/nfalm_checker.sv @@
// port-level checks of the nfa longest match engine, bound to the top level
// depends on nfalm_pkg and assert_macros.svh
`include "assert_macros.svh"

module nfalm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [nfalm_pkg::OpW-1:0]       in_op,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            out_matched,
	input logic [nfalm_pkg::LenFieldW-1:0] out_length
);

	logic in_beat;
	logic out_free;

	assign in_beat  = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	// stalled result beat holds
	`ASSERT_DFLT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_matched) && $stable(out_length)))

	// no new item while a result is stalled
	`ASSERT_DFLT(a_stall_blocks_in, (out_valid && !out_ready) |-> !in_ready)

	// start and load items never produce a result
	`ASSERT_DFLT(a_start_no_result, (in_beat && out_free && (in_op == nfalm_pkg::OpStart)) |=> !out_valid)
	`ASSERT_DFLT(a_load_no_result, (in_beat && out_free && (in_op == nfalm_pkg::OpLoad)) |=> !out_valid)

endmodule

bind nfa_longest_match_engine nfalm_checker u_nfalm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item_in.valid),
	.in_ready    (item_in.ready),
	.in_op       (item_in.op),
	.out_valid   (result_out.valid),
	.out_ready   (result_out.ready),
	.out_matched (result_out.matched),
	.out_length  (result_out.length)
);
